[rtl/core/pmst_pkg.sv]
// ============================================================================
// pmst_pkg: shared types and constants for the Prim spanning-tree engine
// Field widths, heap key limits, controller states, datapath ops and status.
// ============================================================================
package pmst_pkg;

    localparam int ACT_W    = 1;
    localparam int VERT_W   = 6;
    localparam int KEY_W    = 24;
    localparam int PARENT_W = 7;
    localparam int CFG_W    = 7;

    localparam int NODES_DEF     = 64;
    localparam int ADJ_SLOTS_DEF = 2048;

    localparam logic [CFG_W-1:0]    NODE_COUNT_RST = 7'd64;
    localparam logic [KEY_W-1:0]    INF_KEY        = 24'd10000000;
    localparam logic [PARENT_W-1:0] PARENT_NONE    = 7'h7F;
    localparam logic [ACT_W-1:0]    ACT_RUN        = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD_A,
        ST_ADD_A,
        ST_ADD_RD_B,
        ST_ADD_B,
        ST_BUILD,
        ST_INS_START,
        ST_SU_CHECK,
        ST_SU_CMP,
        ST_POP,
        ST_POP_TAKE,
        ST_SD_CHECK,
        ST_SD_CMP,
        ST_RELAX_START,
        ST_RELAX_HEAD,
        ST_RELAX_EDGE,
        ST_RELAX_POS,
        ST_RELAX_KEY,
        ST_NEXT_SLOT,
        ST_OUT_RD,
        ST_OUT_LD
    } pmst_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MARK_DROP,
        OP_LATCH_EDGE,
        OP_LIST_RD_A,
        OP_APPEND_A,
        OP_LIST_RD_B,
        OP_APPEND_B,
        OP_RUN_INIT,
        OP_BUILD_STEP,
        OP_INS_START,
        OP_SU_READ,
        OP_SU_MOVE,
        OP_PLACE,
        OP_POP_READ,
        OP_POP_TAKE,
        OP_SD_READ,
        OP_SD_MOVE,
        OP_MARK_VISIT,
        OP_LIST_RD_U,
        OP_SLOT_FIRST,
        OP_POS_READ,
        OP_KEY_READ,
        OP_RELAX_UPD,
        OP_SLOT_NEXT,
        OP_OUT_INIT,
        OP_I_INC,
        OP_PAR_READ,
        OP_OUT_LOAD,
        OP_CLEAR
    } pmst_op_t;

    typedef struct packed {
        pmst_op_t op;
    } pmst_cmd_t;

    typedef struct packed {
        logic is_run;
        logic edge_skip;
        logic pool_full;
        logic build_last;
        logic heap_empty;
        logic su_top;
        logic su_swap;
        logic sd_leaf;
        logic sd_swap;
        logic u_skip;
        logic relax_ok;
        logic relax_upd;
        logic slot_tail;
        logic out_done;
        logic out_skip;
        logic out_free;
    } pmst_stat_t;

endpackage

[rtl/core/pmst_channels.sv]
// ============================================================================
// pmst_channels: valid/ready channels of the Prim spanning-tree engine
// Item input, result output and vertex-count configuration write.
// ============================================================================
interface pmst_in_if;
    import pmst_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [VERT_W-1:0]   end_a;
    logic [VERT_W-1:0]   end_b;
    logic [KEY_W-1:0]    weight;
    logic [VERT_W-1:0]   start_vertex;
    modport source (output valid, action, end_a, end_b, weight, start_vertex, input ready);
    modport sink   (input valid, action, end_a, end_b, weight, start_vertex, output ready);
endinterface

interface pmst_out_if;
    import pmst_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [VERT_W-1:0]          vertex;
    logic signed [PARENT_W-1:0] parent_vertex;
    logic                       edges_dropped;
    logic                       last;
    modport source (output valid, vertex, parent_vertex, edges_dropped, last, input ready);
    modport sink   (input valid, vertex, parent_vertex, edges_dropped, last, output ready);
endinterface

interface pmst_cfg_if;
    import pmst_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/prim_mst_indexed_heap.sv]
// ============================================================================
// prim_mst_indexed_heap: Prim minimum spanning tree over an indexed min-heap
// Loads undirected edges into linked adjacency lists, then runs Prim from a
// start vertex and streams the parent of every other vertex.
// ============================================================================
//  channel | dir | words                                    | handshake
//  --------+-----+------------------------------------------+-------------
//  cmd     | in  | add edge (a, b, weight) or run (start)   | valid/ready
//  res     | out | vertex, parent (-1 unreached), drop, last| valid/ready
//  cfg     | in  | node_count                               | valid/ready
//
//  Add edge: list read and slot append per direction, over one list memory port.
//  Run: build pass, then per pop a heap read, take and sift-down, per list entry a
//  position read, key read and sift-up on update; the heap memory has one write port.
//  Drain: a parent read and a result load per result, plus any stall on res. No clearing
//  pass after reset: list and visited state live in flops cleared at once.
//  cmd is taken only between words; cfg is always ready.
module prim_mst_indexed_heap #(
    parameter int NODES     = pmst_pkg::NODES_DEF,
    parameter int ADJ_SLOTS = pmst_pkg::ADJ_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pmst_in_if.sink     cmd,
    pmst_out_if.source  res,
    pmst_cfg_if.sink    cfg
);
    import pmst_pkg::*;

    pmst_cmd_t  ctl;
    pmst_stat_t stat;
    logic       in_ready;

    pmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    pmst_dp #(
        .NODES     (NODES),
        .ADJ_SLOTS (ADJ_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.data),
        .action        (cmd.action),
        .end_a         (cmd.end_a),
        .end_b         (cmd.end_b),
        .weight        (cmd.weight),
        .start_vertex  (cmd.start_vertex),
        .res_ready     (res.ready),
        .res_valid     (res.valid),
        .vertex        (res.vertex),
        .parent_vertex (res.parent_vertex),
        .edges_dropped (res.edges_dropped),
        .last          (res.last)
    );

    assign cmd.ready = in_ready;
    assign cfg.ready = 1'b1;

    // a run holds off new words until its final result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> !cmd.ready)
        else $error("cmd ready while a run still has results to send");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(!cmd.ready))
        else $error("result appeared without a run in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last) |=> !res.valid)
        else $error("result word followed the final word of a run");

endmodule

[rtl/core/pmst_ctrl.sv]
// ============================================================================
// pmst_ctrl: sequencer for edge loads, heap walk and result drain
// Steps the datapath one op per cycle from its status flags, waiting while res stalls.
// ============================================================================
module pmst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pmst_pkg::pmst_stat_t  stat,
    output pmst_pkg::pmst_cmd_t   ctl
);
    import pmst_pkg::*;

    pmst_state_t state_reg, state_next;
    logic        su_ret_reg, su_ret_next;   // 1: sift-up came from an edge relax

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            su_ret_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            su_ret_reg <= su_ret_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        su_ret_next = su_ret_reg;
        ctl.op      = OP_NONE;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (stat.is_run)
                    begin
                        ctl.op     = OP_RUN_INIT;
                        state_next = ST_BUILD;
                    end
                    else if (stat.edge_skip)
                    begin
                        ctl.op = OP_NONE;
                    end
                    else if (stat.pool_full)
                    begin
                        ctl.op = OP_MARK_DROP;
                    end
                    else
                    begin
                        ctl.op     = OP_LATCH_EDGE;
                        state_next = ST_ADD_RD_A;
                    end
                end
            end
            ST_ADD_RD_A:
            begin
                ctl.op     = OP_LIST_RD_A;
                state_next = ST_ADD_A;
            end
            ST_ADD_A:
            begin
                ctl.op     = OP_APPEND_A;
                state_next = ST_ADD_RD_B;
            end
            ST_ADD_RD_B:
            begin
                ctl.op     = OP_LIST_RD_B;
                state_next = ST_ADD_B;
            end
            ST_ADD_B:
            begin
                ctl.op     = OP_APPEND_B;
                state_next = ST_IDLE;
            end
            ST_BUILD:
            begin
                ctl.op = OP_BUILD_STEP;
                if (stat.build_last)
                    state_next = ST_INS_START;
            end
            ST_INS_START:
            begin
                ctl.op      = OP_INS_START;
                su_ret_next = 1'b0;
                state_next  = ST_SU_CHECK;
            end
            ST_SU_CHECK:
            begin
                if (stat.su_top)
                begin
                    ctl.op     = OP_PLACE;
                    state_next = su_ret_reg ? ST_NEXT_SLOT : ST_POP;
                end
                else
                begin
                    ctl.op     = OP_SU_READ;
                    state_next = ST_SU_CMP;
                end
            end
            ST_SU_CMP:
            begin
                if (stat.su_swap)
                begin
                    ctl.op     = OP_SU_MOVE;
                    state_next = ST_SU_CHECK;
                end
                else
                begin
                    ctl.op     = OP_PLACE;
                    state_next = su_ret_reg ? ST_NEXT_SLOT : ST_POP;
                end
            end
            ST_POP:
            begin
                if (stat.heap_empty)
                begin
                    ctl.op     = OP_OUT_INIT;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    ctl.op     = OP_POP_READ;
                    state_next = ST_POP_TAKE;
                end
            end
            ST_POP_TAKE:
            begin
                ctl.op     = OP_POP_TAKE;
                state_next = ST_SD_CHECK;
            end
            ST_SD_CHECK:
            begin
                if (stat.sd_leaf)
                begin
                    ctl.op     = OP_PLACE;
                    state_next = ST_RELAX_START;
                end
                else
                begin
                    ctl.op     = OP_SD_READ;
                    state_next = ST_SD_CMP;
                end
            end
            ST_SD_CMP:
            begin
                if (stat.sd_swap)
                begin
                    ctl.op     = OP_SD_MOVE;
                    state_next = ST_SD_CHECK;
                end
                else
                begin
                    ctl.op     = OP_PLACE;
                    state_next = ST_RELAX_START;
                end
            end
            ST_RELAX_START:
            begin
                if (stat.u_skip)
                begin
                    ctl.op     = OP_MARK_VISIT;
                    state_next = ST_POP;
                end
                else
                begin
                    ctl.op     = OP_LIST_RD_U;
                    state_next = ST_RELAX_HEAD;
                end
            end
            ST_RELAX_HEAD:
            begin
                ctl.op     = OP_SLOT_FIRST;
                state_next = ST_RELAX_EDGE;
            end
            ST_RELAX_EDGE:
            begin
                if (stat.relax_ok)
                begin
                    ctl.op     = OP_POS_READ;
                    state_next = ST_RELAX_POS;
                end
                else
                begin
                    state_next = ST_NEXT_SLOT;
                end
            end
            ST_RELAX_POS:
            begin
                ctl.op     = OP_KEY_READ;
                state_next = ST_RELAX_KEY;
            end
            ST_RELAX_KEY:
            begin
                if (stat.relax_upd)
                begin
                    ctl.op      = OP_RELAX_UPD;
                    su_ret_next = 1'b1;
                    state_next  = ST_SU_CHECK;
                end
                else
                begin
                    state_next = ST_NEXT_SLOT;
                end
            end
            ST_NEXT_SLOT:
            begin
                if (stat.slot_tail)
                begin
                    ctl.op     = OP_MARK_VISIT;
                    state_next = ST_POP;
                end
                else
                begin
                    ctl.op     = OP_SLOT_NEXT;
                    state_next = ST_RELAX_EDGE;
                end
            end
            ST_OUT_RD:
            begin
                priority if (stat.out_done)
                begin
                    ctl.op     = OP_CLEAR;
                    state_next = ST_IDLE;
                end
                else if (stat.out_skip)
                begin
                    ctl.op = OP_I_INC;
                end
                else
                begin
                    ctl.op     = OP_PAR_READ;
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = OP_OUT_LOAD;
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/pmst_dp.sv]
// ============================================================================
// pmst_dp: adjacency pool, indexed min-heap and result register
// Executes one controller op per cycle over registered-read memories.
// ============================================================================
module pmst_dp #(
    parameter int NODES     = pmst_pkg::NODES_DEF,
    parameter int ADJ_SLOTS = pmst_pkg::ADJ_SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmst_pkg::pmst_cmd_t                  ctl,
    output pmst_pkg::pmst_stat_t                 stat,
    input  logic                                 cfg_we,
    input  logic [pmst_pkg::CFG_W-1:0]           cfg_data,
    input  logic [pmst_pkg::ACT_W-1:0]           action,
    input  logic [pmst_pkg::VERT_W-1:0]          end_a,
    input  logic [pmst_pkg::VERT_W-1:0]          end_b,
    input  logic [pmst_pkg::KEY_W-1:0]           weight,
    input  logic [pmst_pkg::VERT_W-1:0]          start_vertex,
    input  logic                                 res_ready,
    output logic                                 res_valid,
    output logic [pmst_pkg::VERT_W-1:0]          vertex,
    output logic signed [pmst_pkg::PARENT_W-1:0] parent_vertex,
    output logic                                 edges_dropped,
    output logic                                 last
);
    import pmst_pkg::*;

    localparam int VW  = $clog2(NODES);
    localparam int HW  = $clog2(NODES + 1);
    localparam int SW  = $clog2(ADJ_SLOTS);
    localparam int SCW = $clog2(ADJ_SLOTS + 1);
    localparam int IW  = VW + KEY_W;        // heap item {vertex, key}
    localparam int EW  = VW + KEY_W;        // slot entry {neighbor, weight}

    // memories
    logic [IW-1:0]   heap_mem [0:NODES];
    logic [HW-1:0]   pos_mem  [0:NODES-1];
    logic [VW:0]     par_mem  [0:NODES-1];
    logic [EW-1:0]   slot_mem [0:ADJ_SLOTS-1];
    logic [SW-1:0]   nxt_mem  [0:ADJ_SLOTS-1];
    logic [2*SW-1:0] list_mem [0:NODES-1];

    logic [IW-1:0]   heap_rd_a_reg, heap_rd_b_reg;
    logic [HW-1:0]   pos_rd_reg;
    logic [VW:0]     par_rd_reg;
    logic [EW-1:0]   slot_rd_reg;
    logic [SW-1:0]   nxt_rd_reg;
    logic [2*SW-1:0] list_rd_reg;

    // registers
    logic [CFG_W-1:0] node_count_reg, node_count_next;
    logic [SCW-1:0]   sc_reg, sc_next;
    logic             dropped_reg, dropped_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [NODES-1:0] nonempty_reg, nonempty_next;
    logic [HW-1:0]    len_reg, len_next;
    logic             out_valid_reg, out_valid_next;

    logic [VW-1:0]    a_reg, a_next, b_reg, b_next, s_reg, s_next, u_reg, u_next;
    logic [KEY_W-1:0] w_reg, w_next;
    logic [HW-1:0]    i_reg, i_next, idx_reg, idx_next;
    logic [VW-1:0]    cur_v_reg, cur_v_next;
    logic [KEY_W-1:0] cur_k_reg, cur_k_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [VERT_W-1:0]   out_vertex_reg, out_vertex_next;
    logic [PARENT_W-1:0] out_parent_reg, out_parent_next;
    logic                out_drop_reg, out_drop_next, out_last_reg, out_last_next;

    // memory controls
    logic            heap_we, heap_re_a, heap_re_b;
    logic [HW-1:0]   heap_waddr, heap_raddr_a, heap_raddr_b;
    logic [IW-1:0]   heap_wdata;
    logic            pos_we, pos_re;
    logic [VW-1:0]   pos_waddr, pos_raddr;
    logic [HW-1:0]   pos_wdata;
    logic            par_we, par_re;
    logic [VW-1:0]   par_waddr, par_raddr;
    logic [VW:0]     par_wdata;
    logic            slot_we, slot_re, nxt_we;
    logic [SW-1:0]   slot_waddr, slot_raddr, nxt_waddr, nxt_wdata;
    logic [EW-1:0]   slot_wdata;
    logic            list_we, list_re;
    logic [VW-1:0]   list_waddr, list_raddr;
    logic [2*SW-1:0] list_wdata;

    // derived values
    logic [HW-1:0]    n_eff;
    logic [VW-1:0]    own, oth;
    logic [SW-1:0]    list_head, list_tail;
    logic [VW-1:0]    slot_v;
    logic [KEY_W-1:0] slot_w;
    logic [HW:0]      l_w, r_w;
    logic             pick_r;
    logic [IW-1:0]    sel_item;
    logic [HW-1:0]    sel_idx;
    logic             is_last;

    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = HW'(1);
        else if (32'(node_count_reg) > NODES)
            n_eff = HW'(NODES);
        else
            n_eff = HW'(node_count_reg);
    end

    assign own       = (ctl.op == OP_APPEND_B) ? b_reg : a_reg;
    assign oth       = (ctl.op == OP_APPEND_B) ? a_reg : b_reg;
    assign list_head = list_rd_reg[2*SW-1:SW];
    assign list_tail = list_rd_reg[SW-1:0];
    assign slot_v    = slot_rd_reg[EW-1 -: VW];
    assign slot_w    = slot_rd_reg[KEY_W-1:0];

    assign l_w      = (HW+1)'(idx_reg) << 1;
    assign r_w      = l_w + (HW+1)'(1);
    // equal child keys go right
    assign pick_r   = (r_w <= (HW+1)'(len_reg)) &&
                      !(heap_rd_a_reg[KEY_W-1:0] < heap_rd_b_reg[KEY_W-1:0]);
    assign sel_item = pick_r ? heap_rd_b_reg : heap_rd_a_reg;
    assign sel_idx  = pick_r ? HW'(r_w) : HW'(l_w);

    assign is_last = ((HW+1)'(i_reg) + (HW+1)'(1) == (HW+1)'(n_eff)) ||
                     (((HW+1)'(i_reg) + (HW+1)'(2) == (HW+1)'(n_eff)) &&
                      ((HW+1)'(s_reg) + (HW+1)'(1) == (HW+1)'(n_eff)));

    always_comb
    begin
        stat.is_run     = (action == ACT_RUN);
        stat.edge_skip  = (end_a == end_b) || (32'(end_a) >= 32'(n_eff)) ||
                          (32'(end_b) >= 32'(n_eff));
        stat.pool_full  = 32'(sc_reg) > ADJ_SLOTS - 2;
        stat.build_last = ((HW+1)'(i_reg) + (HW+1)'(1) == (HW+1)'(n_eff));
        stat.heap_empty = (len_reg == '0);
        stat.su_top     = (idx_reg == HW'(1));
        stat.su_swap    = heap_rd_a_reg[KEY_W-1:0] > cur_k_reg;
        stat.sd_leaf    = l_w > (HW+1)'(len_reg);
        stat.sd_swap    = cur_k_reg > sel_item[KEY_W-1:0];
        stat.u_skip     = visited_reg[u_reg] || !nonempty_reg[u_reg];
        stat.relax_ok   = ((HW+1)'(slot_v) < (HW+1)'(n_eff)) && !visited_reg[slot_v];
        stat.relax_upd  = (pos_rd_reg <= len_reg) &&
                          (heap_rd_a_reg[KEY_W-1:0] > cur_k_reg);
        stat.slot_tail  = (slot_reg == list_tail);
        stat.out_done   = (i_reg == n_eff);
        stat.out_skip   = (i_reg == HW'(s_reg));
        stat.out_free   = !out_valid_reg || res_ready;
    end

    always_comb
    begin
        node_count_next = cfg_we ? cfg_data : node_count_reg;
        sc_next         = sc_reg;
        dropped_next    = dropped_reg;
        visited_next    = visited_reg;
        nonempty_next   = nonempty_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        a_next          = a_reg;
        b_next          = b_reg;
        s_next          = s_reg;
        u_next          = u_reg;
        w_next          = w_reg;
        i_next          = i_reg;
        idx_next        = idx_reg;
        cur_v_next      = cur_v_reg;
        cur_k_next      = cur_k_reg;
        slot_next       = slot_reg;
        out_vertex_next = out_vertex_reg;
        out_parent_next = out_parent_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;

        heap_we      = 1'b0;
        heap_waddr   = idx_reg;
        heap_wdata   = {cur_v_reg, cur_k_reg};
        heap_re_a    = 1'b0;
        heap_raddr_a = idx_reg;
        heap_re_b    = 1'b0;
        heap_raddr_b = len_reg;
        pos_we       = 1'b0;
        pos_waddr    = cur_v_reg;
        pos_wdata    = idx_reg;
        pos_re       = 1'b0;
        pos_raddr    = slot_v;
        par_we       = 1'b0;
        par_waddr    = cur_v_reg;
        par_wdata    = {1'b0, u_reg};
        par_re       = 1'b0;
        par_raddr    = VW'(i_reg);
        slot_we      = 1'b0;
        slot_waddr   = SW'(sc_reg);
        slot_wdata   = {oth, w_reg};
        nxt_we       = 1'b0;
        nxt_waddr    = list_tail;
        nxt_wdata    = SW'(sc_reg);
        slot_re      = 1'b0;
        slot_raddr   = list_head;
        list_we      = 1'b0;
        list_waddr   = own;
        list_wdata   = {nonempty_reg[own] ? list_head : SW'(sc_reg), SW'(sc_reg)};
        list_re      = 1'b0;
        list_raddr   = a_reg;

        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_MARK_DROP:
            begin
                dropped_next = 1'b1;
            end
            OP_LATCH_EDGE:
            begin
                a_next = VW'(end_a);
                b_next = VW'(end_b);
                w_next = weight;
            end
            OP_LIST_RD_A:
            begin
                list_re    = 1'b1;
                list_raddr = a_reg;
            end
            OP_LIST_RD_B:
            begin
                list_re    = 1'b1;
                list_raddr = b_reg;
            end
            OP_APPEND_A, OP_APPEND_B:
            begin
                slot_we            = 1'b1;
                nxt_we             = nonempty_reg[own];
                list_we            = 1'b1;
                nonempty_next[own] = 1'b1;
                sc_next            = sc_reg + SCW'(1);
            end
            OP_RUN_INIT:
            begin
                s_next       = (32'(start_vertex) >= 32'(n_eff)) ? '0 : VW'(start_vertex);
                i_next       = '0;
                len_next     = '0;
                visited_next = '0;
            end
            OP_BUILD_STEP:
            begin
                par_we    = 1'b1;
                par_waddr = VW'(i_reg);
                par_wdata = {1'b1, {VW{1'b0}}};
                // keys all equal here, so each insert stays at the tail
                if (i_reg != HW'(s_reg))
                begin
                    heap_we    = 1'b1;
                    heap_waddr = len_reg + HW'(1);
                    heap_wdata = {VW'(i_reg), INF_KEY};
                    pos_we     = 1'b1;
                    pos_waddr  = VW'(i_reg);
                    pos_wdata  = len_reg + HW'(1);
                    len_next   = len_reg + HW'(1);
                end
                i_next = i_reg + HW'(1);
            end
            OP_INS_START:
            begin
                len_next   = len_reg + HW'(1);
                idx_next   = len_reg + HW'(1);
                cur_v_next = s_reg;
                cur_k_next = '0;
            end
            OP_SU_READ:
            begin
                heap_re_a    = 1'b1;
                heap_raddr_a = idx_reg >> 1;
            end
            OP_SU_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = heap_rd_a_reg;
                pos_we     = 1'b1;
                pos_waddr  = heap_rd_a_reg[IW-1 -: VW];
                idx_next   = idx_reg >> 1;
            end
            OP_PLACE:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            OP_POP_READ:
            begin
                heap_re_a    = 1'b1;
                heap_raddr_a = HW'(1);
                heap_re_b    = 1'b1;
                heap_raddr_b = len_reg;
            end
            OP_POP_TAKE:
            begin
                u_next     = heap_rd_a_reg[IW-1 -: VW];
                cur_v_next = heap_rd_b_reg[IW-1 -: VW];
                cur_k_next = heap_rd_b_reg[KEY_W-1:0];
                len_next   = len_reg - HW'(1);
                idx_next   = HW'(1);
            end
            OP_SD_READ:
            begin
                heap_re_a    = 1'b1;
                heap_raddr_a = HW'(l_w);
                heap_re_b    = 1'b1;
                heap_raddr_b = HW'(r_w);
            end
            OP_SD_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = sel_item;
                pos_we     = 1'b1;
                pos_waddr  = sel_item[IW-1 -: VW];
                idx_next   = sel_idx;
            end
            OP_MARK_VISIT:
            begin
                visited_next[u_reg] = 1'b1;
            end
            OP_LIST_RD_U:
            begin
                list_re    = 1'b1;
                list_raddr = u_reg;
            end
            OP_SLOT_FIRST:
            begin
                slot_re    = 1'b1;
                slot_raddr = list_head;
                slot_next  = list_head;
            end
            OP_POS_READ:
            begin
                pos_re     = 1'b1;
                pos_raddr  = slot_v;
                cur_v_next = slot_v;
                cur_k_next = slot_w;
            end
            OP_KEY_READ:
            begin
                heap_re_a    = 1'b1;
                heap_raddr_a = pos_rd_reg;
                idx_next     = pos_rd_reg;
            end
            OP_RELAX_UPD:
            begin
                par_we = 1'b1;
            end
            OP_SLOT_NEXT:
            begin
                slot_re    = 1'b1;
                slot_raddr = nxt_rd_reg;
                slot_next  = nxt_rd_reg;
            end
            OP_OUT_INIT:
            begin
                i_next = '0;
            end
            OP_I_INC:
            begin
                i_next = i_reg + HW'(1);
            end
            OP_PAR_READ:
            begin
                par_re = 1'b1;
            end
            OP_OUT_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_vertex_next = VERT_W'(i_reg);
                out_parent_next = par_rd_reg[VW] ? PARENT_NONE
                                                 : PARENT_W'(par_rd_reg[VW-1:0]);
                out_drop_next   = dropped_reg;
                out_last_next   = is_last;
                i_next          = i_reg + HW'(1);
            end
            OP_CLEAR:
            begin
                nonempty_next = '0;
                sc_next       = '0;
                dropped_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            sc_reg         <= '0;
            dropped_reg    <= 1'b0;
            visited_reg    <= '0;
            nonempty_reg   <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            sc_reg         <= sc_next;
            dropped_reg    <= dropped_next;
            visited_reg    <= visited_next;
            nonempty_reg   <= nonempty_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        s_reg          <= s_next;
        u_reg          <= u_next;
        w_reg          <= w_next;
        i_reg          <= i_next;
        idx_reg        <= idx_next;
        cur_v_reg      <= cur_v_next;
        cur_k_reg      <= cur_k_next;
        slot_reg       <= slot_next;
        out_vertex_reg <= out_vertex_next;
        out_parent_reg <= out_parent_next;
        out_drop_reg   <= out_drop_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_waddr] <= heap_wdata;
        if (heap_re_a)
            heap_rd_a_reg <= heap_mem[heap_raddr_a];
        if (heap_re_b)
            heap_rd_b_reg <= heap_mem[heap_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        if (pos_re)
            pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        if (par_re)
            par_rd_reg <= par_mem[par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_waddr] <= nxt_wdata;
        if (slot_re)
            nxt_rd_reg <= nxt_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        if (list_re)
            list_rd_reg <= list_mem[list_raddr];
    end

    assign res_valid     = out_valid_reg;
    assign vertex        = out_vertex_reg;
    assign parent_vertex = out_parent_reg;
    assign edges_dropped = out_drop_reg;
    assign last          = out_last_reg;

endmodule
